>>> rtl/core/segment_intersection_point_defines.svh
// assertion macros used by the segment intersection checker
`ifndef SEGMENT_INTERSECTION_POINT_DEFINES_SVH
`define SEGMENT_INTERSECTION_POINT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SIP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("segment intersection check failed");

// next-cycle implication, sampled on clk, off during reset
`define SIP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("segment intersection check failed");

`endif

>>> rtl/core/sip_pkg.sv
// shared constants for the segment intersection point block
`default_nettype none
package sip_pkg;

  // fixed point format of the coordinates
  localparam int FRAC_BITS = 4;
  localparam logic [FRAC_BITS-1:0] FRAC_HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

  // result coordinate format
  localparam int OUT_W   = 16;
  localparam int OUT_MAX = 32767;
  localparam int OUT_MIN = -32768;

  typedef logic signed [OUT_W-1:0] sip_coord_t;

endpackage
`default_nettype wire

>>> rtl/core/sip_if.sv
// request channels of the segment intersection point block
`default_nettype none

// segment pair request
interface sip_seg_if #(
  parameter int COORD_BITS = 20,
  parameter int ID_BITS    = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_top_x;
  logic signed [COORD_BITS-1:0] a_top_y;
  logic signed [COORD_BITS-1:0] a_bottom_x;
  logic signed [COORD_BITS-1:0] a_bottom_y;
  logic signed [COORD_BITS-1:0] b_top_x;
  logic signed [COORD_BITS-1:0] b_top_y;
  logic signed [COORD_BITS-1:0] b_bottom_x;
  logic signed [COORD_BITS-1:0] b_bottom_y;
  logic [ID_BITS-1:0]           a_top_id;
  logic [ID_BITS-1:0]           a_bottom_id;
  logic [ID_BITS-1:0]           b_top_id;
  logic [ID_BITS-1:0]           b_bottom_id;

  modport source (
    output valid, a_top_x, a_top_y, a_bottom_x, a_bottom_y,
    output b_top_x, b_top_y, b_bottom_x, b_bottom_y,
    output a_top_id, a_bottom_id, b_top_id, b_bottom_id,
    input  ready
  );
  modport sink (
    input  valid, a_top_x, a_top_y, a_bottom_x, a_bottom_y,
    input  b_top_x, b_top_y, b_bottom_x, b_bottom_y,
    input  a_top_id, a_bottom_id, b_top_id, b_bottom_id,
    output ready
  );
endinterface

// crossing point request
interface sip_pt_if import sip_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       hit;
  sip_coord_t cross_x;
  sip_coord_t cross_y;

  modport source (output valid, hit, cross_x, cross_y, input ready);
  modport sink (input valid, hit, cross_x, cross_y, output ready);
endinterface
`default_nettype wire

>>> rtl/core/segment_intersection_point.sv
// Segment intersection point: fully pipelined, one segment pair per cycle
// while the result side does not stall. The pipeline holds six stages of
// rejection tests and products, one restoring-division stage per quotient
// bit (COORD_BITS + 1 of them, both coordinates in parallel), one stage to
// fold the remainder in, and the output register with rounding and
// saturation. A stall at the output freezes the whole pipeline; stages that
// hold no request do not fill meanwhile, and no request is lost or repeated.
`default_nettype none
module segment_intersection_point import sip_pkg::*; #(
  parameter int COORD_BITS = 20,
  parameter int ID_BITS    = 16
) (
  input  wire     clk,
  input  wire     rst_n,
  sip_seg_if.sink in_seg,
  sip_pt_if.source out_pt
);

  localparam int C   = COORD_BITS;
  localparam int DW  = C + 1;          // endpoint differences
  localparam int PW  = 2 * C + 2;      // difference products
  localparam int SW  = 2 * C + 3;      // den, s, t
  localparam int HW  = C + 2;          // low split of s
  localparam int GW  = SW - HW;        // high split of s
  localparam int LW  = HW + DW + 1;
  localparam int HGW = GW + DW + 1;
  localparam int MW  = SW + DW;        // s * edge product
  localparam int QB  = C + 1;          // quotient bits
  localparam int AW  = C + 3;          // crossing coordinate, 1/16 units
  localparam int KW  = AW - FRAC_BITS;
  localparam int EW  = (KW + 1 > OUT_W + 1) ? KW + 1 : OUT_W + 1;
  localparam logic signed [EW-1:0] SAT_HI = EW'(OUT_MAX);
  localparam logic signed [EW-1:0] SAT_LO = EW'(OUT_MIN);

  logic adv;

  // fold the floor remainder into the base coordinate
  function automatic logic signed [AW-1:0] fix_base(
    input logic signed [C-1:0] base,
    input logic [QB-1:0]       q,
    input logic                neg,
    input logic                rz
  );
    logic signed [QB:0] qs;
    qs = $signed({1'b0, q});
    if (neg) qs = rz ? -qs : -qs - (QB + 1)'(1);
    return AW'(base) - AW'(qs);
  endfunction

  // round half away from zero to whole units and saturate
  function automatic logic [OUT_W-1:0] round_sat(
    input logic signed [AW-1:0] a,
    input logic                 rz
  );
    logic [FRAC_BITS-1:0] m;
    logic                 pos;
    logic                 inc;
    logic signed [EW-1:0] res;
    m   = a[FRAC_BITS-1:0];
    pos = !a[AW-1] && (a != '0);
    inc = (m > FRAC_HALF) || ((m == FRAC_HALF) && rz && pos);
    res = EW'($signed(a[AW-1:FRAC_BITS])) + $signed({{(EW-1){1'b0}}, inc});
    if (res > SAT_HI) return SAT_HI[OUT_W-1:0];
    if (res < SAT_LO) return SAT_LO[OUT_W-1:0];
    return res[OUT_W-1:0];
  endfunction

  // whole pipeline moves unless the output holds an untaken result
  logic out_v_r;
  assign adv          = !out_v_r || out_pt.ready;
  assign in_seg.ready = adv;

  // stage 1: shared vertex and bounding box rejection, differences
  logic signed [C-1:0] atx, aty, abx, aby, btx, bty, bbx, bby;
  logic signed [C-1:0] axmin, axmax, aymin, aymax, bxmin, bxmax, bymin, bymax;
  logic [ID_BITS-1:0]  ati, abi, bti, bbi;
  logic                kill1_nxt;
  assign atx = in_seg.a_top_x;
  assign aty = in_seg.a_top_y;
  assign abx = in_seg.a_bottom_x;
  assign aby = in_seg.a_bottom_y;
  assign btx = in_seg.b_top_x;
  assign bty = in_seg.b_top_y;
  assign bbx = in_seg.b_bottom_x;
  assign bby = in_seg.b_bottom_y;
  assign ati = in_seg.a_top_id;
  assign abi = in_seg.a_bottom_id;
  assign bti = in_seg.b_top_id;
  assign bbi = in_seg.b_bottom_id;
  assign axmin = (atx < abx) ? atx : abx;
  assign axmax = (atx < abx) ? abx : atx;
  assign aymin = (aty < aby) ? aty : aby;
  assign aymax = (aty < aby) ? aby : aty;
  assign bxmin = (btx < bbx) ? btx : bbx;
  assign bxmax = (btx < bbx) ? bbx : btx;
  assign bymin = (bty < bby) ? bty : bby;
  assign bymax = (bty < bby) ? bby : bty;
  assign kill1_nxt = (ati == bti) || (abi == bbi) || (ati == bbi) || (abi == bti) ||
                     (axmin > bxmax) || (axmax < bxmin) ||
                     (aymin > bymax) || (aymax < bymin);

  logic                 v1_r, kill1_r;
  logic signed [C-1:0]  atx1_r, aty1_r;
  logic signed [DW-1:0] la_a1_r, lb_a1_r, la_b1_r, lb_b1_r, dx1_r, dy1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_seg.valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      kill1_r <= kill1_nxt;
      atx1_r  <= atx;
      aty1_r  <= aty;
      la_a1_r <= DW'(aby) - DW'(aty);
      lb_a1_r <= DW'(atx) - DW'(abx);
      la_b1_r <= DW'(bby) - DW'(bty);
      lb_b1_r <= DW'(btx) - DW'(bbx);
      dx1_r   <= DW'(btx) - DW'(atx);
      dy1_r   <= DW'(bty) - DW'(aty);
    end
  end

  // stage 2: six difference products
  logic                 v2_r, kill2_r;
  logic signed [C-1:0]  atx2_r, aty2_r;
  logic signed [DW-1:0] la_a2_r, lb_a2_r;
  logic signed [PW-1:0] md1_r, md2_r, ms1_r, ms2_r, mt1_r, mt2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      kill2_r <= kill1_r;
      atx2_r  <= atx1_r;
      aty2_r  <= aty1_r;
      la_a2_r <= la_a1_r;
      lb_a2_r <= lb_a1_r;
      md1_r   <= PW'(la_a1_r) * PW'(lb_b1_r);
      md2_r   <= PW'(lb_a1_r) * PW'(la_b1_r);
      ms1_r   <= PW'(dy1_r) * PW'(lb_b1_r);
      ms2_r   <= PW'(dx1_r) * PW'(la_b1_r);
      mt1_r   <= PW'(dy1_r) * PW'(lb_a1_r);
      mt2_r   <= PW'(dx1_r) * PW'(la_a1_r);
    end
  end

  // stage 3: denominator and segment parameters
  logic                 v3_r, kill3_r;
  logic signed [C-1:0]  atx3_r, aty3_r;
  logic signed [DW-1:0] la_a3_r, lb_a3_r;
  logic signed [SW-1:0] den3_r, s3_r, t3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      kill3_r <= kill2_r;
      atx3_r  <= atx2_r;
      aty3_r  <= aty2_r;
      la_a3_r <= la_a2_r;
      lb_a3_r <= lb_a2_r;
      den3_r  <= SW'(md1_r) - SW'(md2_r);
      s3_r    <= SW'(ms1_r) + SW'(ms2_r);
      t3_r    <= SW'(mt1_r) + SW'(mt2_r);
    end
  end

  // stage 4: parallel and range rejection, sign normalization
  logic den_neg, range_bad;
  assign den_neg   = den3_r[SW-1];
  assign range_bad = den_neg ?
    ((s3_r > 0) || (s3_r < den3_r) || (t3_r > 0) || (t3_r < den3_r)) :
    ((s3_r < 0) || (s3_r > den3_r) || (t3_r < 0) || (t3_r > den3_r));

  logic                 v4_r, kill4_r;
  logic signed [C-1:0]  atx4_r, aty4_r;
  logic signed [DW-1:0] la_a4_r, lb_a4_r;
  logic [SW-1:0]        sn4_r, dd4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= v3_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      kill4_r <= kill3_r || (den3_r == '0) || range_bad;
      atx4_r  <= atx3_r;
      aty4_r  <= aty3_r;
      la_a4_r <= la_a3_r;
      lb_a4_r <= lb_a3_r;
      sn4_r   <= den_neg ? -s3_r : s3_r;
      dd4_r   <= den_neg ? -den3_r : den3_r;
    end
  end

  // stage 5: partial products of s with the first segment's edge
  logic                  v5_r, kill5_r;
  logic signed [C-1:0]   atx5_r, aty5_r;
  logic [SW-1:0]         dd5_r;
  logic signed [LW-1:0]  pxl5_r, pyl5_r;
  logic signed [HGW-1:0] pxh5_r, pyh5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (adv) v5_r <= v4_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      kill5_r <= kill4_r;
      atx5_r  <= atx4_r;
      aty5_r  <= aty4_r;
      dd5_r   <= dd4_r;
      pxl5_r  <= LW'($signed({1'b0, sn4_r[HW-1:0]})) * LW'(lb_a4_r);
      pyl5_r  <= LW'($signed({1'b0, sn4_r[HW-1:0]})) * LW'(la_a4_r);
      pxh5_r  <= HGW'($signed({1'b0, sn4_r[SW-1:HW]})) * HGW'(lb_a4_r);
      pyh5_r  <= HGW'($signed({1'b0, sn4_r[SW-1:HW]})) * HGW'(la_a4_r);
    end
  end

  // stage 6: full products, split into sign and magnitude for the divider
  logic signed [MW-1:0] px, py;
  assign px = (MW'(pxh5_r) <<< HW) + MW'(pxl5_r);
  assign py = (MW'(pyh5_r) <<< HW) + MW'(pyl5_r);

  // divider pipeline, entry 0 is the stage 6 register
  logic                dv_r  [0:QB];
  logic                dk_r  [0:QB];
  logic [SW-1:0]       dd_r  [0:QB];
  logic signed [C-1:0] dax_r [0:QB];
  logic signed [C-1:0] day_r [0:QB];
  logic [MW-1:0]       rx_r  [0:QB];
  logic [MW-1:0]       ry_r  [0:QB];
  logic [QB-1:0]       qx_r  [0:QB];
  logic [QB-1:0]       qy_r  [0:QB];
  logic                nx_r  [0:QB];
  logic                ny_r  [0:QB];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else if (adv) dv_r[0] <= v5_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dk_r[0]  <= kill5_r;
      dd_r[0]  <= dd5_r;
      dax_r[0] <= atx5_r;
      day_r[0] <= aty5_r;
      nx_r[0]  <= px[MW-1];
      rx_r[0]  <= px[MW-1] ? -px : px;
      ny_r[0]  <= !py[MW-1] && (py != '0);
      ry_r[0]  <= py[MW-1] ? -py : py;
      qx_r[0]  <= '0;
      qy_r[0]  <= '0;
    end
  end

  // one restoring step per stage, most significant quotient bit first
  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int SH = QB - 1 - j;
    logic [MW-1:0] subv;
    assign subv = MW'(dd_r[j]) << SH;

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[j+1] <= 1'b0;
      else if (adv) dv_r[j+1] <= dv_r[j];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dk_r[j+1]  <= dk_r[j];
        dd_r[j+1]  <= dd_r[j];
        dax_r[j+1] <= dax_r[j];
        day_r[j+1] <= day_r[j];
        nx_r[j+1]  <= nx_r[j];
        ny_r[j+1]  <= ny_r[j];
        if (rx_r[j] >= subv) begin
          rx_r[j+1] <= rx_r[j] - subv;
          qx_r[j+1] <= qx_r[j] | (QB'(1) << SH);
        end else begin
          rx_r[j+1] <= rx_r[j];
          qx_r[j+1] <= qx_r[j];
        end
        if (ry_r[j] >= subv) begin
          ry_r[j+1] <= ry_r[j] - subv;
          qy_r[j+1] <= qy_r[j] | (QB'(1) << SH);
        end else begin
          ry_r[j+1] <= ry_r[j];
          qy_r[j+1] <= qy_r[j];
        end
      end
    end
  end

  // fold stage: coordinate in 1/16 units with exact-remainder flag
  logic                 vf_r, killf_r, rzx_r, rzy_r;
  logic signed [AW-1:0] ax_r, ay_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vf_r <= 1'b0;
    else if (adv) vf_r <= dv_r[QB];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      killf_r <= dk_r[QB];
      rzx_r   <= (rx_r[QB] == '0);
      rzy_r   <= (ry_r[QB] == '0);
      ax_r    <= fix_base(dax_r[QB], qx_r[QB], nx_r[QB], rx_r[QB] == '0);
      ay_r    <= fix_base(day_r[QB], qy_r[QB], ny_r[QB], ry_r[QB] == '0);
    end
  end

  // output register: rounding, saturation, zero on no hit
  logic             hit_r;
  logic [OUT_W-1:0] cx_r, cy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (adv) out_v_r <= vf_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r <= !killf_r;
      cx_r  <= killf_r ? '0 : round_sat(ax_r, rzx_r);
      cy_r  <= killf_r ? '0 : round_sat(ay_r, rzy_r);
    end
  end

  assign out_pt.valid   = out_v_r;
  assign out_pt.hit     = hit_r;
  assign out_pt.cross_x = cx_r;
  assign out_pt.cross_y = cy_r;

endmodule
`default_nettype wire

>>> rtl/core/sip_checker.sv
// port-level checks for the segment intersection point block
`default_nettype none
`include "segment_intersection_point_defines.svh"
module sip_checker import sip_pkg::*; (
  input wire             clk,
  input wire             rst_n,
  input wire             in_valid,
  input wire             in_ready,
  input wire             out_valid,
  input wire             out_ready,
  input wire             hit,
  input wire [OUT_W-1:0] cross_x,
  input wire [OUT_W-1:0] cross_y
);

  // a stalled result keeps its request and payload
  `SIP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hit) && $stable(cross_x) && $stable(cross_y))

  // a miss always reports the origin
  `SIP_ASSERT_NOW(a_miss_zero, out_valid && !hit, (cross_x == '0) && (cross_y == '0))

  // a stalled result freezes the pipeline, so no request enters
  `SIP_ASSERT_NOW(a_stall_blocks, out_valid && !out_ready, !in_ready)

  // with an idle output the pipeline always takes a request
  `SIP_ASSERT_NOW(a_idle_ready, !out_valid, in_ready || !in_valid)

endmodule

bind segment_intersection_point sip_checker u_sip_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_seg.valid),
  .in_ready  (in_seg.ready),
  .out_valid (out_pt.valid),
  .out_ready (out_pt.ready),
  .hit       (out_pt.hit),
  .cross_x   (out_pt.cross_x),
  .cross_y   (out_pt.cross_y)
);
`default_nettype wire

>>> test/tb_top.sv
// testbench for the segment intersection point block
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import sip_pkg::*;

  localparam int CW = 20;
  localparam int IW = 16;
  localparam int LATENCY = CW + 9;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PAIRS = 1700;

  typedef struct packed {
    logic signed [CW-1:0] atx, aty, abx, aby, btx, bty, bbx, bby;
    logic [IW-1:0] ati, abi, bti, bbi;
  } seg_pair_t;

  typedef struct packed {
    logic       hit;
    sip_coord_t x;
    sip_coord_t y;
  } crossing_t;

  // directed row: pair plus optional typed-in expectation
  typedef struct {
    seg_pair_t pair;
    bit        typed;
    crossing_t want;
  } seg_row_t;

  logic clk;
  logic rst_n;
  int   cycles;
  int   fails;
  int   n_hits;
  int   n_results;

  sip_seg_if #(.COORD_BITS(CW), .ID_BITS(IW)) seg_ch ();
  sip_pt_if pt_ch ();

  segment_intersection_point #(.COORD_BITS(CW), .ID_BITS(IW)) uut (
    .clk(clk), .rst_n(rst_n), .in_seg(seg_ch.sink), .out_pt(pt_ch.source)
  );

  crossing_t crossing_q[$];
  seg_row_t  rows[$];

  // clock and cycle limit
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // round n/d half away from zero, d > 0, saturate to output range
  function automatic sip_coord_t round_clamp(logic signed [127:0] n, logic signed [127:0] d);
    logic signed [127:0] mag;
    logic signed [127:0] q;
    mag = (n < 0) ? -n : n;
    q = (2 * mag + d) / (2 * d);
    if (n < 0) return (q > 32768) ? sip_coord_t'(OUT_MIN) : sip_coord_t'(-q);
    return (q > OUT_MAX) ? sip_coord_t'(OUT_MAX) : sip_coord_t'(q);
  endfunction

  // exact crossing point of two segments
  function automatic crossing_t predict_crossing(seg_pair_t p);
    crossing_t r;
    logic signed [127:0] atx, aty, abx, aby, btx, bty, bbx, bby;
    logic signed [127:0] la_a, lb_a, la_b, lb_b, den, dx, dy, s, t, nx, ny, d;
    r = '0;
    atx = p.atx; aty = p.aty; abx = p.abx; aby = p.aby;
    btx = p.btx; bty = p.bty; bbx = p.bbx; bby = p.bby;
    if (p.ati == p.bti || p.abi == p.bbi || p.ati == p.bbi || p.abi == p.bti) return r;
    if ((atx < abx ? atx : abx) > (btx > bbx ? btx : bbx) ||
        (atx > abx ? atx : abx) < (btx < bbx ? btx : bbx) ||
        (aty < aby ? aty : aby) > (bty > bby ? bty : bby) ||
        (aty > aby ? aty : aby) < (bty < bby ? bty : bby)) return r;
    la_a = aby - aty; lb_a = atx - abx;
    la_b = bby - bty; lb_b = btx - bbx;
    den = la_a * lb_b - lb_a * la_b;
    if (den == 0) return r;
    dx = btx - atx; dy = bty - aty;
    s = dy * lb_b + dx * la_b;
    t = dy * lb_a + dx * la_a;
    if (den > 0) begin
      if (s < 0 || s > den || t < 0 || t > den) return r;
    end else begin
      if (s > 0 || s < den || t > 0 || t < den) return r;
    end
    nx = atx * den - s * lb_a;
    ny = aty * den + s * la_a;
    d = den * 16;
    if (d < 0) begin
      d = -d; nx = -nx; ny = -ny;
    end
    r.hit = 1'b1;
    r.x = round_clamp(nx, d);
    r.y = round_clamp(ny, d);
    return r;
  endfunction

  function automatic seg_pair_t make_pair(int atx, int aty, int abx, int aby,
                                          int btx, int bty, int bbx, int bby);
    seg_pair_t p;
    p.atx = CW'(atx); p.aty = CW'(aty); p.abx = CW'(abx); p.aby = CW'(aby);
    p.btx = CW'(btx); p.bty = CW'(bty); p.bbx = CW'(bbx); p.bby = CW'(bby);
    p.ati = IW'(1); p.abi = IW'(2); p.bti = IW'(3); p.bbi = IW'(4);
    return p;
  endfunction

  function automatic seg_row_t row(seg_pair_t p, bit typed, logic hit, int x, int y);
    seg_row_t r;
    r.pair = p;
    r.typed = typed;
    r.want.hit = hit;
    r.want.x = sip_coord_t'(x);
    r.want.y = sip_coord_t'(y);
    return r;
  endfunction

  function automatic logic signed [CW-1:0] rnd_coord(int span);
    if (span == 0) return CW'($urandom);
    return CW'($urandom_range(2 * span) - span);
  endfunction

  // random pair: mostly crossing-prone segments around a shared center
  function automatic seg_pair_t rand_pair();
    seg_pair_t p;
    int span, cx, cy, mode;
    mode = $urandom_range(9);
    span = (mode < 2) ? 0 : (mode < 5 ? 64 : (mode < 8 ? 4096 : 500000));
    cx = (span == 0) ? 0 : $urandom_range(2 * (524287 - span)) - (524287 - span);
    cy = (span == 0) ? 0 : $urandom_range(2 * (524287 - span)) - (524287 - span);
    p.atx = CW'(cx + rnd_coord(span)); p.aty = CW'(cy + rnd_coord(span));
    p.abx = CW'(cx + rnd_coord(span)); p.aby = CW'(cy + rnd_coord(span));
    p.btx = CW'(cx + rnd_coord(span)); p.bty = CW'(cy + rnd_coord(span));
    p.bbx = CW'(cx + rnd_coord(span)); p.bby = CW'(cy + rnd_coord(span));
    if ($urandom_range(9) == 0) begin
      // parallel geometry
      p.btx = CW'(p.atx + 16); p.bty = p.aty; p.bbx = CW'(p.abx + 16); p.bby = p.aby;
    end
    if ($urandom_range(7) == 0) begin
      p.ati = IW'($urandom_range(3)); p.abi = IW'($urandom_range(3));
      p.bti = IW'($urandom_range(3)); p.bbi = IW'($urandom_range(3));
    end else begin
      p.ati = IW'($urandom); p.abi = IW'($urandom);
      p.bti = IW'($urandom); p.bbi = IW'($urandom);
      if (p.ati == p.bti || p.ati == p.bbi || p.abi == p.bti || p.abi == p.bbi) begin
        p.ati = 16'h0000; p.abi = 16'hffff; p.bti = 16'h5555; p.bbi = 16'haaaa;
      end
    end
    return p;
  endfunction

  function automatic int gap_len();
    int g;
    g = $urandom_range(99);
    if (g < 50) return 0;
    if (g < 95) return $urandom_range(3);
    return $urandom_range(40);
  endfunction

  task automatic send_pair(seg_pair_t p);
    int g;
    g = gap_len();
    repeat (g) begin
      seg_ch.valid <= 1'b0;
      @(negedge clk);
    end
    seg_ch.valid      <= 1'b1;
    seg_ch.a_top_x    <= p.atx; seg_ch.a_top_y    <= p.aty;
    seg_ch.a_bottom_x <= p.abx; seg_ch.a_bottom_y <= p.aby;
    seg_ch.b_top_x    <= p.btx; seg_ch.b_top_y    <= p.bty;
    seg_ch.b_bottom_x <= p.bbx; seg_ch.b_bottom_y <= p.bby;
    seg_ch.a_top_id   <= p.ati; seg_ch.a_bottom_id <= p.abi;
    seg_ch.b_top_id   <= p.bti; seg_ch.b_bottom_id <= p.bbi;
    do @(posedge clk); while (!seg_ch.ready);
    @(negedge clk);
  endtask

  // result sink with random stalls
  initial begin
    int stall;
    pt_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        pt_ch.ready <= 1'b0;
        stall = stall - 1;
      end else begin
        pt_ch.ready <= 1'b1;
        stall = ($urandom_range(3) == 0) ? gap_len() : 0;
      end
    end
  end

  // check accepted results against the oldest expectation
  always @(posedge clk) begin
    crossing_t want;
    if (rst_n && pt_ch.valid && pt_ch.ready) begin
      n_results++;
      if (crossing_q.size() == 0) begin
        $error("unexpected result hit=%0d", pt_ch.hit);
        fails++;
      end else begin
        want = crossing_q.pop_front();
        if (pt_ch.hit) n_hits++;
        if (pt_ch.hit !== want.hit) begin
          $error("hit: expected %0d, actual %0d", want.hit, pt_ch.hit);
          fails++;
        end
        if (pt_ch.cross_x !== want.x) begin
          $error("cross_x: expected %0d, actual %0d", want.x, pt_ch.cross_x);
          fails++;
        end
        if (pt_ch.cross_y !== want.y) begin
          $error("cross_y: expected %0d, actual %0d", want.y, pt_ch.cross_y);
          fails++;
        end
      end
    end
  end

  // stimulus
  initial begin
    seg_pair_t p;
    crossing_t model;
    int waited;
    cycles = 0; fails = 0; n_hits = 0; n_results = 0;
    rst_n = 1'b0;
    seg_ch.valid = 1'b0;
    seg_ch.a_top_x = '0; seg_ch.a_top_y = '0; seg_ch.a_bottom_x = '0; seg_ch.a_bottom_y = '0;
    seg_ch.b_top_x = '0; seg_ch.b_top_y = '0; seg_ch.b_bottom_x = '0; seg_ch.b_bottom_y = '0;
    seg_ch.a_top_id = '0; seg_ch.a_bottom_id = '0; seg_ch.b_top_id = '0;
    seg_ch.b_bottom_id = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // simple cross at the origin, whole units of 16
    rows.push_back(row(make_pair(-160, -160, 160, 160, -160, 160, 160, -160), 1, 1, 0, 0));
    // cross at (5,3)
    rows.push_back(row(make_pair(0, 48, 160, 48, 80, 0, 80, 96), 1, 1, 5, 3));
    // exact halves away from zero: point 8/16 and -8/16
    rows.push_back(row(make_pair(8, -8, 8, 8, 0, 0, 16, 0), 1, 1, 1, 0));
    rows.push_back(row(make_pair(-8, -8, -8, 8, -16, 8, 0, 8), 1, 1, -1, 1));
    // shared identifier in each cross pair
    p = make_pair(-160, -160, 160, 160, -160, 160, 160, -160);
    p.bti = p.ati; rows.push_back(row(p, 1, 0, 0, 0));
    p = make_pair(-160, -160, 160, 160, -160, 160, 160, -160);
    p.bbi = p.abi; rows.push_back(row(p, 1, 0, 0, 0));
    p = make_pair(-160, -160, 160, 160, -160, 160, 160, -160);
    p.bbi = p.ati; rows.push_back(row(p, 1, 0, 0, 0));
    p = make_pair(-160, -160, 160, 160, -160, 160, 160, -160);
    p.bti = p.abi; rows.push_back(row(p, 1, 0, 0, 0));
    // same id within one segment is fine
    p = make_pair(-160, -160, 160, 160, -160, 160, 160, -160);
    p.abi = p.ati; p.bbi = p.bti; rows.push_back(row(p, 1, 1, 0, 0));
    // disjoint bounding boxes
    rows.push_back(row(make_pair(0, 0, 16, 16, 100, 100, 200, 200), 1, 0, 0, 0));
    // parallel and degenerate
    rows.push_back(row(make_pair(0, 0, 160, 160, 16, 0, 176, 160), 1, 0, 0, 0));
    rows.push_back(row(make_pair(32, 32, 32, 32, 0, 0, 64, 64), 1, 0, 0, 0));
    // boxes overlap but parameter out of range
    rows.push_back(row(make_pair(0, 0, 160, 160, 100, 0, 160, 50), 1, 0, 0, 0));
    // touching at an endpoint counts
    rows.push_back(row(make_pair(0, 0, 160, 160, 160, 160, 320, 0), 1, 1, 10, 10));
    // coordinate extremes, saturation both ways
    rows.push_back(row(make_pair(-524288, -524288, 524287, 524287,
                                 -524288, 524287, 524287, -524288), 0, 0, 0, 0));
    rows.push_back(row(make_pair(524287, 524287, 524287, 500000,
                                 500000, 510000, 524287, 510000), 1, 1, 32767, 31875));
    rows.push_back(row(make_pair(-524288, -524288, -524288, -500000,
                                 -500000, -510000, -524288, -510000), 1, 1, -32768, -31875));
    rows.push_back(row(make_pair(-524288, 524287, 524287, -524288,
                                 -524288, -524288, 524287, 524287), 0, 0, 0, 0));
    // id extremes
    p = make_pair(-160, -160, 160, 160, -160, 160, 160, -160);
    p.ati = 16'hffff; p.abi = 16'h0000; p.bti = 16'h7fff; p.bbi = 16'h8000;
    rows.push_back(row(p, 1, 1, 0, 0));

    // directed part
    foreach (rows[i]) begin
      model = predict_crossing(rows[i].pair);
      if (rows[i].typed && model !== rows[i].want)
        $display("note: directed row %0d typed value differs from prediction", i);
      crossing_q.push_back(rows[i].typed ? rows[i].want : model);
      send_pair(rows[i].pair);
    end
    seg_ch.valid <= 1'b0;

    // hold off until every expected result has arrived
    while (crossing_q.size() != 0) @(negedge clk);

    // random part
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      p = rand_pair();
      crossing_q.push_back(predict_crossing(p));
      send_pair(p);
      if (i == RANDOM_PAIRS / 2) begin
        seg_ch.valid <= 1'b0;
        while (crossing_q.size() != 0) @(negedge clk);
      end
    end
    seg_ch.valid <= 1'b0;

    // drain
    waited = 0;
    while (crossing_q.size() != 0 && waited < 200 * LATENCY) begin
      @(negedge clk);
      waited++;
    end
    repeat (2 * LATENCY) @(negedge clk);
    if (crossing_q.size() != 0) begin
      $error("%0d expected results never arrived", crossing_q.size());
      fails++;
    end
    $display("covered %0d segment pairs, %0d results checked, %0d crossings",
             rows.size() + RANDOM_PAIRS, n_results, n_hits);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
+incdir+rtl/core
rtl/core/sip_pkg.sv
rtl/core/sip_if.sv
rtl/core/segment_intersection_point.sv
rtl/core/sip_checker.sv
test/tb_top.sv
